FILE: sv/osts_pkg.sv
// Shared types and constants for the order slot table.
`default_nettype none
package osts_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned QtyW    = 24;
  localparam int unsigned CountW  = 5;
  localparam int unsigned SharesW = 29;
  localparam logic [TimeW-1:0] FillDelayRst = 32'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_SW_RD,
    ST_SW_EV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             side;
    logic [QtyW-1:0]  qty;
    logic [TimeW-1:0] stamp;
  } slot_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic ins_place;
    logic sw_read;
    logic sw_eval;
    logic idx_inc;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cur_busy;
    logic idx_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: sv/order_slot_table_with_fill_sweep.sv
// Order slot table: insert into lowest empty slot, sweep frees aged orders.
// Insert: result strobe after the search from slot 0 up; out_accepted stays low when the table is full.
// Sweep: result strobe after every slot has been visited (registered slot read, age compare).
// Busy stays high through the strobe cycle and the next item is accepted in the cycle
//   after it; the receiver cannot stall.
// Sync active-low reset empties all slots, clears totals, fill_delay=1000000.
`default_nettype none
module order_slot_table_with_fill_sweep #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_op,
  input  wire logic [osts_pkg::TimeW-1:0]           in_now_time,
  input  wire logic                                 in_side,
  input  wire logic [osts_pkg::QtyW-1:0]            in_qty,
  output logic                                      out_valid,
  output logic                                      out_accepted,
  output logic [osts_pkg::CountW-1:0]               out_filled_count,
  output logic signed [osts_pkg::SharesW-1:0]       out_settled_delta,
  output logic [osts_pkg::CountW-1:0]               out_in_flight_total,
  output logic signed [osts_pkg::SharesW-1:0]       out_net_in_flight_shares,
  input  wire logic                                 cfg_we,
  input  wire logic [osts_pkg::TimeW-1:0]           cfg_data
);

  osts_pkg::cmd_t  cmd;
  osts_pkg::stat_t stat;

  osts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  osts_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .stat                     (stat),
    .cfg_we                   (cfg_we),
    .cfg_data                 (cfg_data),
    .in_now_time              (in_now_time),
    .in_side                  (in_side),
    .in_qty                   (in_qty),
    .out_accepted             (out_accepted),
    .out_filled_count         (out_filled_count),
    .out_settled_delta        (out_settled_delta),
    .out_in_flight_total      (out_in_flight_total),
    .out_net_in_flight_shares (out_net_in_flight_shares)
  );

endmodule
`default_nettype wire

FILE: sv/osts_ctrl.sv
// Sequencer for insert search and sweep scan.
`default_nettype none
module osts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            in_op,
  input  wire osts_pkg::stat_t stat,
  output osts_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 out_valid
);

  osts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      osts_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_op ? osts_pkg::ST_SW_RD : osts_pkg::ST_INS_CHK;
        end
      end
      osts_pkg::ST_INS_CHK: begin
        if (!stat.cur_busy) begin
          cmd.ins_place = 1'b1;
          state_nxt     = osts_pkg::ST_DONE;
        end else if (stat.idx_last) begin
          state_nxt = osts_pkg::ST_DONE;   // table full
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      osts_pkg::ST_SW_RD: begin
        cmd.sw_read = 1'b1;
        state_nxt   = osts_pkg::ST_SW_EV;
      end
      osts_pkg::ST_SW_EV: begin
        cmd.sw_eval = 1'b1;
        if (stat.idx_last) begin
          state_nxt = osts_pkg::ST_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = osts_pkg::ST_SW_RD;
        end
      end
      osts_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = osts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = osts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/osts_dp.sv
// Slot memory, busy bits, running totals and result registers.
`default_nettype none
module osts_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire osts_pkg::cmd_t                       cmd,
  output osts_pkg::stat_t                           stat,
  input  wire logic                                 cfg_we,
  input  wire logic [osts_pkg::TimeW-1:0]           cfg_data,
  input  wire logic [osts_pkg::TimeW-1:0]           in_now_time,
  input  wire logic                                 in_side,
  input  wire logic [osts_pkg::QtyW-1:0]            in_qty,
  output logic                                      out_accepted,
  output logic [osts_pkg::CountW-1:0]               out_filled_count,
  output logic signed [osts_pkg::SharesW-1:0]       out_settled_delta,
  output logic [osts_pkg::CountW-1:0]               out_in_flight_total,
  output logic signed [osts_pkg::SharesW-1:0]       out_net_in_flight_shares
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(ENTRIES - 1);

  osts_pkg::slot_t slot_mem [ENTRIES];
  osts_pkg::slot_t rd_r;

  logic [ENTRIES-1:0]                 busy_r;
  logic [IdxW-1:0]                    idx_r;
  logic [osts_pkg::TimeW-1:0]         fill_delay_r;
  logic [osts_pkg::TimeW-1:0]         now_r;
  logic                               side_r;
  logic [osts_pkg::QtyW-1:0]          qty_r;
  logic [osts_pkg::CountW-1:0]        total_r;
  logic [osts_pkg::SharesW-1:0]       net_r;
  logic                               acc_r;
  logic [osts_pkg::CountW-1:0]        filled_r;
  logic [osts_pkg::SharesW-1:0]       settled_r;

  logic [osts_pkg::SharesW-1:0]       ins_shares;
  logic [osts_pkg::SharesW-1:0]       rd_shares;
  logic [osts_pkg::TimeW-1:0]         age;
  logic                               due;

  assign stat.cur_busy = busy_r[idx_r];
  assign stat.idx_last = (idx_r == IdxLast);

  // Buy is +qty, sell is -qty, in 29-bit two's complement.
  assign ins_shares = side_r ? (osts_pkg::SharesW'(0) - osts_pkg::SharesW'(qty_r))
                             : osts_pkg::SharesW'(qty_r);
  assign rd_shares  = rd_r.side ? (osts_pkg::SharesW'(0) - osts_pkg::SharesW'(rd_r.qty))
                                : osts_pkg::SharesW'(rd_r.qty);
  assign age = now_r - rd_r.stamp;
  assign due = busy_r[idx_r] && (age >= fill_delay_r);

  always_ff @(posedge clk) begin
    if (cmd.ins_place) begin
      slot_mem[idx_r] <= '{side: side_r, qty: qty_r, stamp: now_r};
    end
    if (cmd.sw_read) begin
      rd_r <= slot_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= '0;
      total_r      <= '0;
      net_r        <= '0;
      fill_delay_r <= osts_pkg::FillDelayRst;
      idx_r        <= '0;
    end else begin
      if (cfg_we) begin
        fill_delay_r <= cfg_data;
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IdxW'(1);
      end
      if (cmd.ins_place) begin
        busy_r[idx_r] <= 1'b1;
        total_r       <= total_r + osts_pkg::CountW'(1);
        net_r         <= net_r + ins_shares;
      end
      if (cmd.sw_eval && due) begin
        busy_r[idx_r] <= 1'b0;
        total_r       <= total_r - osts_pkg::CountW'(1);
        net_r         <= net_r - rd_shares;
      end
    end
  end

  // Item operands and per-item result accumulators.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= in_now_time;
      side_r    <= in_side;
      qty_r     <= in_qty;
      acc_r     <= 1'b0;
      filled_r  <= '0;
      settled_r <= '0;
    end else begin
      if (cmd.ins_place) begin
        acc_r <= 1'b1;
      end
      if (cmd.sw_eval && due) begin
        filled_r  <= filled_r + osts_pkg::CountW'(1);
        settled_r <= settled_r + rd_shares;
      end
    end
  end

  assign out_accepted             = acc_r;
  assign out_filled_count         = filled_r;
  assign out_settled_delta        = settled_r;
  assign out_in_flight_total      = total_r;
  assign out_net_in_flight_shares = net_r;

endmodule
`default_nettype wire
